@@ rtl/tbl_pkg.sv @@
// Shared constants and types for the per-client token bucket limiter.
package tbl_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 4096;
    localparam int unsigned DEF_PROBE_LEN   = 16;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  BYTE_MASK = 8'hff;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_RATE   = 2'd1;
    localparam logic [1:0] CFG_BURST  = 2'd2;

    localparam logic        RST_ENABLE = 1'b1;
    localparam logic [15:0] RST_RATE   = 16'd100;
    localparam logic [15:0] RST_BURST  = 16'd200;

    localparam logic [32:0] ELAPSED_SAT = 33'h1_0000_0000;

    typedef struct packed {
        logic        valid;
        logic [31:0] client;
        logic [31:0] tokens;
        logic [47:0] last_seen;
    } slot_t;

    localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

@@ rtl/tbl_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module tbl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/per_client_token_bucket_limiter_core.sv @@
// Top level of the per-client token bucket limiter: hash, probe, refill and spend.
//
//  channel   direction  handshake            payload
//  in        request    in_valid / in_stall  client_ip, now_time
//  out       result     out_valid/out_stall  allowed, retry_after_seconds
//  cfg       write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An enabled request is accepted, hashed with one FNV multiply per client byte, reduced
// modulo TABLE_DEPTH four bits at a time, then walks up to PROBE_LEN slots of the slot RAM
// (one read per cycle), and finishes with elapsed time, refill multiply and write-back.
// A disabled request goes straight from accept to its result. After reset the slot RAM is
// swept clear, every slot, before the first request is taken. A result waits in its
// output register under out_stall; the next request is taken meanwhile.
module per_client_token_bucket_limiter_core
    import tbl_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int unsigned PROBE_LEN   = DEF_PROBE_LEN
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] client_ip,
    input  logic [47:0] now_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        allowed,
    output logic        retry_after_seconds,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned RW = IW + 1;
    localparam int unsigned PW = $clog2(PROBE_LEN + 1);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_ELAP  = 3'd5;
    localparam logic [2:0] S_MUL   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic        enable_reg;
    logic [15:0] rate_reg, burst_reg;

    logic [31:0] ip_reg, ip_next;
    logic [47:0] now_reg, now_next;
    logic        dis_reg, dis_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] hash_reg, hash_next;
    logic [IW-1:0] rem_reg, rem_next;
    logic [IW-1:0] clr_reg, clr_next;

    logic [IW-1:0] iss_idx_reg, iss_idx_next;
    logic [PW-1:0] iss_cnt_reg, iss_cnt_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic [PW-1:0] evl_cnt_reg, evl_cnt_next;
    logic          vic_have_reg, vic_have_next;
    logic [IW-1:0] vic_idx_reg, vic_idx_next;
    logic [47:0]   vic_last_reg, vic_last_next;

    logic [IW-1:0] sel_idx_reg, sel_idx_next;
    logic          sel_new_reg, sel_new_next;
    logic [31:0]   sel_tok_reg, sel_tok_next;
    logic [47:0]   sel_last_reg, sel_last_next;
    logic          refill_reg, refill_next;
    logic [32:0]   elap_reg, elap_next;
    logic [48:0]   prod_reg, prod_next;

    logic out_valid_reg, out_valid_next;
    logic allowed_reg, allowed_next;
    logic retry_reg, retry_next;

    logic          rd_en;
    logic [SLOT_W-1:0] rd_raw;
    slot_t         rd_slot;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    slot_t         wr_slot;

    logic          out_free;
    logic [RW-1:0] mod_r;
    logic [31:0]   mod_sh;
    logic [RW-1:0] inc_idx;
    logic [48:0]   diff;
    logic [31:0]   full;
    logic [31:0]   tok_base;
    logic [49:0]   level;
    logic [31:0]   tok_fill;
    logic          can_spend;

    tbl_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_slots (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_slot),
        .rd_en  (rd_en),
        .rd_addr(iss_idx_reg),
        .rd_data(rd_raw)
    );

    assign rd_slot   = slot_t'(rd_raw);
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign allowed   = allowed_reg;
    assign retry_after_seconds = retry_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = {burst_reg, 16'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= RST_ENABLE;
            rate_reg   <= RST_RATE;
            burst_reg  <= RST_BURST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_RATE:   rate_reg   <= cfg_data;
                CFG_BURST:  burst_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Reduce four hash bits per cycle, most significant first.
    always_comb
    begin
        mod_r  = {1'b0, rem_reg};
        mod_sh = hash_reg;
        for (int j = 0; j < 4; j++)
        begin
            mod_r  = {mod_r[IW-1:0], mod_sh[31]};
            mod_sh = {mod_sh[30:0], 1'b0};
            if (mod_r >= RW'(TABLE_DEPTH))
            begin
                mod_r = mod_r - RW'(TABLE_DEPTH);
            end
        end
    end

    always_comb
    begin
        inc_idx = {1'b0, iss_idx_reg} + RW'(1);
        if (inc_idx == RW'(TABLE_DEPTH))
        begin
            inc_idx = '0;
        end
    end

    always_comb
    begin
        diff     = {1'b0, now_reg} - {1'b0, sel_last_reg};
        tok_base = sel_new_reg ? full : sel_tok_reg;
        level    = {18'd0, tok_base} + {1'b0, prod_reg};
        tok_fill = tok_base;
        if (refill_reg)
        begin
            tok_fill = (level > {18'd0, full}) ? full : level[31:0];
        end
        can_spend = (tok_fill[31:16] != 16'd0);
    end

    always_comb
    begin
        state_next    = state_reg;
        ip_next       = ip_reg;
        now_next      = now_reg;
        dis_next      = dis_reg;
        step_next     = step_reg;
        hash_next     = hash_reg;
        rem_next      = rem_reg;
        clr_next      = clr_reg;
        iss_idx_next  = iss_idx_reg;
        iss_cnt_next  = iss_cnt_reg;
        pend_next     = 1'b0;
        pend_idx_next = iss_idx_reg;
        evl_cnt_next  = evl_cnt_reg;
        vic_have_next = vic_have_reg;
        vic_idx_next  = vic_idx_reg;
        vic_last_next = vic_last_reg;
        sel_idx_next  = sel_idx_reg;
        sel_new_next  = sel_new_reg;
        sel_tok_next  = sel_tok_reg;
        sel_last_next = sel_last_reg;
        refill_next   = refill_reg;
        elap_next     = elap_reg;
        prod_next     = prod_reg;
        out_valid_next = out_valid_reg && out_stall;
        allowed_next  = allowed_reg;
        retry_next    = retry_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = sel_idx_reg;
        wr_slot       = '0;

        case (state_reg)
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                clr_next = clr_reg + IW'(1);
                if ({1'b0, clr_reg} == RW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ip_next   = client_ip;
                    now_next  = now_time;
                    dis_next  = !enable_reg;
                    hash_next = FNV_BASIS;
                    step_next = '0;
                    state_next = enable_reg ? S_HASH : S_FIN;
                end
            end
            S_HASH:
            begin
                hash_next = (hash_reg ^ {24'd0, ip_reg[8*step_reg[1:0] +: 8] & BYTE_MASK})
                            * FNV_PRIME;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                rem_next  = mod_r[IW-1:0];
                hash_next = mod_sh;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    iss_idx_next  = mod_r[IW-1:0];
                    iss_cnt_next  = '0;
                    evl_cnt_next  = '0;
                    vic_have_next = 1'b0;
                    state_next    = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (iss_cnt_reg < PW'(PROBE_LEN))
                begin
                    rd_en        = 1'b1;
                    pend_next    = 1'b1;
                    iss_cnt_next = iss_cnt_reg + PW'(1);
                    iss_idx_next = inc_idx[IW-1:0];
                end
                if (pend_reg)
                begin
                    evl_cnt_next = evl_cnt_reg + PW'(1);
                    if (!rd_slot.valid || rd_slot.client == ip_reg)
                    begin
                        sel_idx_next  = pend_idx_reg;
                        sel_new_next  = !rd_slot.valid;
                        sel_tok_next  = rd_slot.tokens;
                        sel_last_next = rd_slot.last_seen;
                        state_next    = S_ELAP;
                    end
                    else
                    begin
                        if (!vic_have_reg || rd_slot.last_seen < vic_last_reg)
                        begin
                            vic_have_next = 1'b1;
                            vic_idx_next  = pend_idx_reg;
                            vic_last_next = rd_slot.last_seen;
                        end
                        // Window exhausted: evict the oldest slot seen.
                        if (evl_cnt_reg == PW'(PROBE_LEN - 1))
                        begin
                            sel_idx_next = (!vic_have_reg || rd_slot.last_seen < vic_last_reg)
                                           ? pend_idx_reg : vic_idx_reg;
                            sel_new_next = 1'b1;
                            state_next   = S_ELAP;
                        end
                    end
                end
            end
            S_ELAP:
            begin
                refill_next = !sel_new_reg && !diff[48] && (diff[47:0] != 48'd0);
                elap_next   = (diff[47:0] > {15'd0, ELAPSED_SAT}) ? ELAPSED_SAT
                                                                  : diff[32:0];
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = elap_reg * rate_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (dis_reg)
                    begin
                        allowed_next = 1'b1;
                        retry_next   = 1'b0;
                    end
                    else
                    begin
                        allowed_next = can_spend;
                        retry_next   = !can_spend;
                        wr_en             = 1'b1;
                        wr_slot.valid     = 1'b1;
                        wr_slot.client    = ip_reg;
                        wr_slot.tokens    = can_spend ? (tok_fill - 32'h0001_0000) : tok_fill;
                        wr_slot.last_seen = (sel_new_reg || refill_reg) ? now_reg
                                                                        : sel_last_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg       <= ip_next;
        now_reg      <= now_next;
        dis_reg      <= dis_next;
        step_reg     <= step_next;
        hash_reg     <= hash_next;
        rem_reg      <= rem_next;
        iss_idx_reg  <= iss_idx_next;
        iss_cnt_reg  <= iss_cnt_next;
        pend_idx_reg <= pend_idx_next;
        evl_cnt_reg  <= evl_cnt_next;
        vic_have_reg <= vic_have_next;
        vic_idx_reg  <= vic_idx_next;
        vic_last_reg <= vic_last_next;
        sel_idx_reg  <= sel_idx_next;
        sel_new_reg  <= sel_new_next;
        sel_tok_reg  <= sel_tok_next;
        sel_last_reg <= sel_last_next;
        refill_reg   <= refill_next;
        elap_reg     <= elap_next;
        prod_reg     <= prod_next;
        allowed_reg  <= allowed_next;
        retry_reg    <= retry_next;
    end

    a_retry_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (retry_after_seconds == !allowed))
        else $error("retry flag disagrees with verdict");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_CLR || state_reg == S_FIN))
        else $error("slot write outside clear or write-back");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("request accepted but block stayed idle");

    a_pend_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(rd_en))
        else $error("probe evaluated without a read");

endmodule
